// ===== sv/idl_pkg.sv =====
// Package for the indexed deque list: field widths, defaults, mode and status codes.
`default_nettype none

package idl_pkg;

   // Parameter defaults
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the request and response transactions
   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_ADD_FRONT  = 3'd0,
      MODE_ADD_BACK   = 3'd1,
      MODE_TAKE_FRONT = 3'd2,
      MODE_TAKE_BACK  = 3'd3,
      MODE_INSERT     = 3'd4,
      MODE_REMOVE     = 3'd5,
      MODE_READ       = 3'd6,
      MODE_CLEAR      = 3'd7
   } mode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== sv/indexed_deque_list_top.sv =====
// Indexed deque list: bounded ordered record list held in a RAM, shifted by a sequencer.
// Refused requests and clear answer in the cycle after acceptance; a read steps through
// POS_RD, POS_CAP; pop/remove then add TAKE_RD/WR, push/insert PUT_RD/WR, per entry moved.
// Each moved entry costs one RAM read and one RAM write through the single +/-1 index unit.
// A new request is accepted once busy drops, in the cycle that carries the result strobe.
// Synchronous reset empties the list; RAM contents are not cleared (never read unwritten).
`default_nettype none

module indexed_deque_list_top #(
   parameter int DEPTH      = idl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = idl_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [idl_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [idl_pkg::POS_W-1:0]     req_position,
   input  wire logic [idl_pkg::DATA_W-1:0]    req_data_in,
   output logic                               rsp_valid,
   output logic [idl_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [idl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [idl_pkg::COUNT_W-1:0]        rsp_count_after
);
   import idl_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT_RD,
      ST_PUT_WR,
      ST_POS_RD,
      ST_POS_CAP,
      ST_TAKE_RD,
      ST_TAKE_WR
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic                  is_read_ff, is_read_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // RAM and its ports
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_q_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // Shared index unit: idx +/- 1
   logic                  step_dec;
   logic [CW-1:0]         step_sum;

   mode_type              mode;
   logic [CMPW-1:0]       pos_ext;
   logic [CMPW-1:0]       cnt_ext;
   logic                  accept;

   assign mode     = mode_type'(req_mode);
   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);

   assign step_dec = (state_ff == ST_PUT_RD) || (state_ff == ST_PUT_WR);
   assign step_sum = CW'(idx_ff) + (step_dec ? {CW{1'b1}} : CW'(1));

   // RAM port control
   always_comb begin
      rd_en   = (state_ff == ST_POS_RD) || (state_ff == ST_PUT_RD) ||
                (state_ff == ST_TAKE_RD);
      rd_addr = (state_ff == ST_POS_RD) ? pos_ff : step_sum[AW-1:0];
      wr_en   = (state_ff == ST_PUT_WR) || (state_ff == ST_TAKE_WR) ||
                ((state_ff == ST_PUT_RD) && (idx_ff == pos_ff));
      wr_addr = idx_ff;
      wr_data = (state_ff == ST_PUT_RD) ? data_ff : rd_q_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      data_in       = data_ff;
      value_in      = value_ff;
      is_read_in    = is_read_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in  = '0;
               rsp_count_in = COUNT_W'(count_ff);
               data_in      = DATA_WIDTH'(req_data_in);
               idx_in       = count_ff[AW-1:0];
               is_read_in   = (mode == MODE_READ);
               case (mode)
                  MODE_ADD_FRONT, MODE_ADD_BACK, MODE_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else if ((mode == MODE_INSERT) && (pos_ext > cnt_ext)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        if (mode == MODE_ADD_FRONT) begin
                           pos_in = '0;
                        end else if (mode == MODE_ADD_BACK) begin
                           pos_in = count_ff[AW-1:0];
                        end else begin
                           pos_in = AW'(req_position);
                        end
                        state_in = ST_PUT_RD;
                     end
                  end
                  MODE_TAKE_FRONT, MODE_TAKE_BACK, MODE_REMOVE, MODE_READ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else if (((mode == MODE_REMOVE) || (mode == MODE_READ)) &&
                                  (pos_ext >= cnt_ext)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        if (mode == MODE_TAKE_FRONT) begin
                           pos_in = '0;
                        end else if (mode == MODE_TAKE_BACK) begin
                           pos_in = AW'(count_ff - CW'(1));
                        end else begin
                           pos_in = AW'(req_position);
                        end
                        state_in = ST_POS_RD;
                     end
                  end
                  default: begin
                     // clear
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end

         // Open a slot: move entry idx-1 to idx down to the target position
         ST_PUT_RD: begin
            if (idx_ff == pos_ff) begin
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = COUNT_W'(count_ff + CW'(1));
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_PUT_WR;
            end
         end
         ST_PUT_WR: begin
            idx_in   = step_sum[AW-1:0];
            state_in = ST_PUT_RD;
         end

         // Fetch the entry at the target position
         ST_POS_RD: begin
            state_in = ST_POS_CAP;
         end
         ST_POS_CAP: begin
            value_in = rd_q_ff;
            idx_in   = pos_ff;
            if (is_read_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = DATA_W'(rd_q_ff);
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_TAKE_RD;
            end
         end

         // Close the gap: move entry idx+1 to idx up to the tail
         ST_TAKE_RD: begin
            if (step_sum < count_ff) begin
               state_in = ST_TAKE_WR;
            end else begin
               count_in      = count_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = DATA_W'(value_ff);
               rsp_count_in  = COUNT_W'(count_ff - CW'(1));
               state_in      = ST_IDLE;
            end
         end
         ST_TAKE_WR: begin
            idx_in   = step_sum[AW-1:0];
            state_in = ST_TAKE_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      data_ff       <= data_in;
      value_ff      <= value_in;
      is_read_ff    <= is_read_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept) || $past(busy)))
      else $error("response without a transaction");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction dropped");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("RAM write beyond list tail");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (count_ff == CW'(DEPTH)))
      else $error("full status on a list that is not full");

endmodule

`default_nettype wire
